// ===== src/mcw_pkg.sv =====
`timescale 1ns / 1ps

package mcw_pkg;

    localparam int SYM_W   = 8;
    localparam int SYM_NUM = 256;
    localparam int MISS_W  = 9;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PAT   = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    typedef struct packed {
        logic             rd_en;
        logic [SYM_W-1:0] rd_addr;
        logic             wr_en;
        logic [SYM_W-1:0] wr_addr;
        logic             wr_pat;
        logic             clr;
    } mcw_cnt_ctl_t;

endpackage

// ===== src/mcw_count_mem.sv =====
`timescale 1ns / 1ps

module mcw_count_mem #(
    parameter int NEED_W = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mcw_pkg::mcw_cnt_ctl_t       ctl,
    input  logic signed [NEED_W-1:0]    wr_need,
    output logic signed [NEED_W-1:0]    rd_need,
    output logic                        rd_pat
);
    import mcw_pkg::*;

    logic [NEED_W:0]      mem [SYM_NUM];
    logic [NEED_W:0]      rd_data_reg;
    logic                 rd_valid_reg;
    logic [SYM_NUM-1:0]   valid_reg;
    logic [SYM_NUM-1:0]   valid_next;

    // entries never written since clear read as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr)
        begin
            valid_next = '0;
        end
        else if (ctl.wr_en)
        begin
            valid_next[ctl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= {ctl.wr_pat, wr_need};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_pat  = rd_valid_reg & rd_data_reg[NEED_W];
    assign rd_need = rd_valid_reg ? signed'(rd_data_reg[NEED_W-1:0]) : '0;

endmodule

// ===== src/mcw_text_mem.sv =====
`timescale 1ns / 1ps

module mcw_text_mem #(
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [mcw_pkg::SYM_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [mcw_pkg::SYM_W-1:0] rd_data
);
    import mcw_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/minimum_covering_window_core.sv =====
// pattern byte: a count table read-modify-write, nothing when dropped
// text byte: a count table read-modify-write, none with an empty pattern or when dropped, plus
//   per step of the left edge, a text buffer read then a count table read-modify-write
// clear and end items are handled in the idle state; the result item is registered and shows the next cycle
// reset (async, active low) clears control state; count table reads as zero through
//   per-entry valid bits, the text buffer holds no defined contents until written
`timescale 1ns / 1ps

module minimum_covering_window_core #(
    parameter int MAX_TEXT    = 4096,
    parameter int MAX_PATTERN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  symbol,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [11:0] window_start,
    output logic [12:0] window_length,
    output logic        overflow
);
    import mcw_pkg::*;

    localparam int IDX_W  = $clog2(MAX_TEXT);
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int NEED_W = $clog2(MAX_TEXT + MAX_PATTERN + 1) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PWB  = 3'd1;
    localparam logic [2:0] S_TWB  = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  right_reg, right_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [IDX_W-1:0]  best_start_reg, best_start_next;
    logic [CNT_W-1:0]  best_len_reg, best_len_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [MISS_W-1:0] miss_reg, miss_next;
    logic              ovf_reg, ovf_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [IDX_W-1:0]  j_reg, j_next;

    logic              rv_reg, rv_next;
    logic              found_reg, found_next;
    logic [11:0]       start_reg, start_next;
    logic [12:0]       len_reg, len_next;
    logic              ovfo_reg, ovfo_next;

    logic                     accept;
    logic                     go_pat;
    logic                     go_text;
    logic                     has_best;
    logic                     offer;
    logic [CNT_W-1:0]         offer_len;
    logic                     offer_wins;
    mcw_cnt_ctl_t             cnt_ctl;
    logic signed [NEED_W-1:0] cnt_wr_need;
    logic signed [NEED_W-1:0] cnt_rd_need;
    logic                     cnt_rd_pat;
    logic signed [NEED_W-1:0] need_dec;
    logic signed [NEED_W-1:0] need_inc;
    logic                     txt_wr_en;
    logic                     txt_rd_en;
    logic [IDX_W-1:0]         txt_rd_addr;
    logic [SYM_W-1:0]         txt_rd_data;

    assign item_stall = (state_reg != S_IDLE) || (op == OP_END && rv_reg && result_stall);
    assign accept     = item_valid && !item_stall;
    assign go_pat     = accept && op == OP_PAT && right_reg == '0
                        && plen_reg < PLEN_W'(MAX_PATTERN);
    assign go_text    = accept && op == OP_TEXT && right_reg < CNT_W'(MAX_TEXT);
    assign txt_wr_en  = go_text;

    assign need_dec   = cnt_rd_need - NEED_W'(1);
    assign need_inc   = cnt_rd_need + NEED_W'(1);
    assign offer_len  = CNT_W'(j_reg) - left_reg + CNT_W'(1);
    assign offer_wins = (best_len_reg == '0) || (offer_len < best_len_reg);
    assign has_best   = (plen_reg != '0) && (best_len_reg != '0);

    always_comb
    begin
        state_next      = state_reg;
        right_next      = right_reg;
        left_next       = left_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        plen_next       = plen_reg;
        miss_next       = miss_reg;
        ovf_next        = ovf_reg;
        sym_next        = sym_reg;
        j_next          = j_reg;
        rv_next         = rv_reg && result_stall;
        found_next      = found_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        ovfo_next       = ovfo_reg;
        offer           = 1'b0;
        cnt_ctl         = '0;
        cnt_wr_need     = need_inc;
        txt_rd_en       = 1'b0;
        txt_rd_addr     = left_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            right_next      = '0;
                            left_next       = '0;
                            best_start_next = '0;
                            best_len_next   = '0;
                            plen_next       = '0;
                            miss_next       = '0;
                            ovf_next        = 1'b0;
                            cnt_ctl.clr     = 1'b1;
                        end
                        OP_PAT:
                        begin
                            if (go_pat)
                            begin
                                plen_next       = plen_reg + PLEN_W'(1);
                                sym_next        = symbol;
                                cnt_ctl.rd_en   = 1'b1;
                                cnt_ctl.rd_addr = symbol;
                                state_next      = S_PWB;
                            end
                            else if (right_reg == '0)
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (go_text)
                            begin
                                j_next     = right_reg[IDX_W-1:0];
                                right_next = right_reg + CNT_W'(1);
                                sym_next   = symbol;
                                if (plen_reg != '0)
                                begin
                                    cnt_ctl.rd_en   = 1'b1;
                                    cnt_ctl.rd_addr = symbol;
                                    state_next      = S_TWB;
                                end
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            rv_next    = 1'b1;
                            found_next = has_best;
                            start_next = has_best ? 12'(best_start_reg) : '0;
                            len_next   = has_best ? 13'(best_len_reg) : '0;
                            ovfo_next  = ovf_reg;
                        end
                    endcase
                end
            end
            S_PWB:
            begin
                cnt_ctl.wr_en   = 1'b1;
                cnt_ctl.wr_addr = sym_reg;
                cnt_ctl.wr_pat  = 1'b1;
                cnt_wr_need     = need_inc;
                if (!cnt_rd_pat)
                begin
                    miss_next = miss_reg + MISS_W'(1);
                end
                state_next = S_IDLE;
            end
            S_TWB:
            begin
                if (cnt_rd_pat)
                begin
                    cnt_ctl.wr_en   = 1'b1;
                    cnt_ctl.wr_addr = sym_reg;
                    cnt_ctl.wr_pat  = 1'b1;
                    cnt_wr_need     = need_dec;
                    if (need_dec == '0 && miss_reg != '0)
                    begin
                        miss_next = miss_reg - MISS_W'(1);
                    end
                end
                state_next = S_IDLE;
                if (miss_next == '0)
                begin
                    offer = 1'b1;
                    if (left_reg <= CNT_W'(j_reg))
                    begin
                        txt_rd_en   = 1'b1;
                        txt_rd_addr = left_reg[IDX_W-1:0];
                        state_next  = S_CNT;
                    end
                end
            end
            S_CNT:
            begin
                cnt_ctl.rd_en   = 1'b1;
                cnt_ctl.rd_addr = txt_rd_data;
                state_next      = S_UPD;
            end
            S_UPD:
            begin
                if (cnt_rd_pat)
                begin
                    cnt_ctl.wr_en   = 1'b1;
                    cnt_ctl.wr_addr = txt_rd_data;
                    cnt_ctl.wr_pat  = 1'b1;
                    cnt_wr_need     = need_inc;
                    if (need_inc == NEED_W'(1))
                    begin
                        offer     = 1'b1;
                        miss_next = miss_reg + MISS_W'(1);
                    end
                end
                left_next   = left_reg + CNT_W'(1);
                txt_rd_en   = 1'b1;
                txt_rd_addr = left_next[IDX_W-1:0];
                if (miss_next == '0 && left_next <= CNT_W'(j_reg))
                begin
                    state_next = S_CNT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (offer && offer_wins)
        begin
            best_start_next = left_reg[IDX_W-1:0];
            best_len_next   = offer_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            right_reg      <= '0;
            left_reg       <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            plen_reg       <= '0;
            miss_reg       <= '0;
            ovf_reg        <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            right_reg      <= right_next;
            left_reg       <= left_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            plen_reg       <= plen_next;
            miss_reg       <= miss_next;
            ovf_reg        <= ovf_next;
            rv_reg         <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        j_reg     <= j_next;
        found_reg <= found_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        ovfo_reg  <= ovfo_next;
    end

    mcw_count_mem #(
        .NEED_W (NEED_W)
    ) u_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (cnt_ctl),
        .wr_need (cnt_wr_need),
        .rd_need (cnt_rd_need),
        .rd_pat  (cnt_rd_pat)
    );

    mcw_text_mem #(
        .DEPTH (MAX_TEXT)
    ) u_text (
        .clk     (clk),
        .wr_en   (txt_wr_en),
        .wr_addr (right_reg[IDX_W-1:0]),
        .wr_data (symbol),
        .rd_en   (txt_rd_en),
        .rd_addr (txt_rd_addr),
        .rd_data (txt_rd_data)
    );

    assign result_valid  = rv_reg;
    assign found         = found_reg;
    assign window_start  = start_reg;
    assign window_length = len_reg;
    assign overflow      = ovfo_reg;

endmodule

// ===== tb/minimum_covering_window_checker.sv =====
`timescale 1ns / 1ps

module minimum_covering_window_checker #(
    parameter int MAX_TEXT    = 4096,
    parameter int MAX_PATTERN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  symbol,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        found,
    input  logic [11:0] window_start,
    input  logic [12:0] window_length,
    input  logic        overflow,
    output int          fail_count,
    output int          pending
);
    import mcw_pkg::*;

    typedef struct packed {
        logic        found;
        logic [11:0] start;
        logic [12:0] length;
        logic        overflow;
    } window_rpt_t;

    int               need_cnt [SYM_NUM];
    bit               in_pat [SYM_NUM];
    logic [SYM_W-1:0] text_buf [MAX_TEXT];
    int               missing;
    int               left_idx;
    int               right_idx;
    int               best_start;
    int               best_len;
    int               pat_len;
    bit               text_ovf;
    window_rpt_t      expected_windows [$];
    int               mismatches = 0;

    function void clear_window_state();
        foreach (need_cnt[i])
        begin
            need_cnt[i] = 0;
            in_pat[i]   = 1'b0;
        end
        missing    = 0;
        left_idx   = 0;
        right_idx  = 0;
        best_start = 0;
        best_len   = 0;
        pat_len    = 0;
        text_ovf   = 1'b0;
    endfunction

    function void keep_shorter(int s, int len);
        if (best_len == 0 || len < best_len)
        begin
            best_start = s;
            best_len   = len;
        end
    endfunction

    function void take_pattern_byte(logic [SYM_W-1:0] b);
        if (right_idx != 0)
            return;
        if (pat_len >= MAX_PATTERN)
        begin
            text_ovf = 1'b1;
            return;
        end
        pat_len++;
        need_cnt[b]++;
        if (!in_pat[b])
        begin
            in_pat[b] = 1'b1;
            missing++;
        end
    endfunction

    function void take_text_byte(logic [SYM_W-1:0] b);
        int               j;
        logic [SYM_W-1:0] c;
        if (right_idx >= MAX_TEXT)
        begin
            text_ovf = 1'b1;
            return;
        end
        j = right_idx;
        text_buf[j] = b;
        right_idx++;
        if (pat_len == 0)
            return;
        if (in_pat[b])
        begin
            need_cnt[b]--;
            if (need_cnt[b] == 0 && missing > 0)
                missing--;
        end
        if (missing != 0)
            return;
        keep_shorter(left_idx, j - left_idx + 1);
        // shrink the left edge while the window still covers the pattern
        while (missing == 0 && left_idx <= j && left_idx < MAX_TEXT)
        begin
            c = text_buf[left_idx];
            if (in_pat[c])
            begin
                need_cnt[c]++;
                if (need_cnt[c] == 1)
                begin
                    keep_shorter(left_idx, j - left_idx + 1);
                    missing++;
                end
            end
            left_idx++;
        end
    endfunction

    function window_rpt_t report_window();
        window_rpt_t r;
        r.found    = (pat_len != 0 && best_len != 0);
        r.start    = r.found ? best_start[11:0] : 12'd0;
        r.length   = r.found ? best_len[12:0] : 13'd0;
        r.overflow = text_ovf;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_rpt_t exp_w;
        if (!rst_n)
        begin
            clear_window_state();
            expected_windows.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_windows.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result item with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    exp_w = expected_windows.pop_front();
                    if (found !== exp_w.found || window_start !== exp_w.start ||
                        window_length !== exp_w.length || overflow !== exp_w.overflow)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("%0t: mismatch expected found %0d start %0d length %0d",
                                   $time, exp_w.found, exp_w.start, exp_w.length);
                            $display(" overflow %0d, got found %0d start %0d length %0d overflow %0d",
                                     exp_w.overflow, found, window_start, window_length,
                                     overflow);
                        end
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                case (op)
                    OP_CLEAR: clear_window_state();
                    OP_PAT:   take_pattern_byte(symbol);
                    OP_TEXT:  take_text_byte(symbol);
                    default:  expected_windows.push_back(report_window());
                endcase
            end
            pending    <= expected_windows.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== tb/minimum_covering_window_core_tb.sv =====
`timescale 1ns / 1ps

module minimum_covering_window_core_tb;
    import mcw_pkg::*;

    localparam int MAX_TEXT     = 4096;
    localparam int MAX_PATTERN  = 256;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic        result_valid;
    logic        result_stall;
    logic        found;
    logic [11:0] window_start;
    logic [12:0] window_length;
    logic        overflow;
    int          fail_count;
    int          pending;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int cycle_cnt     = 0;
    int sent_cnt      = 0;
    int idle_mix [4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{22, 22}};

    minimum_covering_window_core #(
        .MAX_TEXT    (MAX_TEXT),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .symbol        (symbol),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .window_start  (window_start),
        .window_length (window_length),
        .overflow      (overflow)
    );

    minimum_covering_window_checker #(
        .MAX_TEXT    (MAX_TEXT),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .symbol        (symbol),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .window_start  (window_start),
        .window_length (window_length),
        .overflow      (overflow),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("** minimum_covering_window_core: FAILED **");
            $finish;
        end
    end

    // receiver side, with a long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    result_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            result_stall <= (int'($urandom_range(99)) < stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] s);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        op         <= o;
        symbol     <= s;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic random_case();
        int         plen;
        int         tlen;
        int         alpha;
        logic [7:0] base;
        plen  = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 0);
        tlen  = $urandom_range(40);
        alpha = $urandom_range(6, 1);
        base  = 8'($urandom_range(255));
        // noise and broken sequences
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(6, 1))
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        if ($urandom_range(9) != 0)
            send_item(OP_CLEAR, 8'($urandom_range(255)));
        repeat (plen)
            send_item(OP_PAT, base + 8'($urandom_range(alpha - 1)));
        repeat (tlen)
        begin
            case ($urandom_range(19))
                0:       send_item(OP_PAT, base + 8'($urandom_range(alpha - 1)));
                1:       send_item(OP_END, 8'($urandom_range(255)));
                2, 3:    send_item(OP_TEXT, 8'($urandom_range(255)));
                default: send_item(OP_TEXT, base + 8'($urandom_range(alpha - 1)));
            endcase
        end
        if ($urandom_range(9) != 0)
            send_item(OP_END, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int mark;
        item_valid = 1'b0;
        op         = OP_CLEAR;
        symbol     = 8'h00;
        rst_n      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty pattern right after reset
        send_item(OP_END, 8'h00);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_PAT, 8'h00);
        send_item(OP_PAT, 8'hFF);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_TEXT, 8'h5A);
        send_item(OP_END, 8'hFF);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_END, 8'h00);
        // pattern byte after text is dropped
        send_item(OP_PAT, 8'hA5);
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_END, 8'h00);
        // text with no pattern
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_TEXT, 8'h41);
        send_item(OP_END, 8'h00);
        // repeated pattern byte, repeated end
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_PAT, 8'h41);
        send_item(OP_PAT, 8'h41);
        send_item(OP_TEXT, 8'h41);
        send_item(OP_END, 8'h00);
        send_item(OP_TEXT, 8'h42);
        send_item(OP_TEXT, 8'h41);
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'hFF);

        // widest window, then text overflow
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_PAT, 8'h61);
        send_item(OP_PAT, 8'h62);
        send_item(OP_TEXT, 8'h61);
        repeat (MAX_TEXT - 2)
            send_item(OP_TEXT, 8'h63);
        send_item(OP_TEXT, 8'h62);
        send_item(OP_END, 8'h00);
        repeat (3)
            send_item(OP_TEXT, 8'h62);
        send_item(OP_END, 8'h00);

        // window at the last text index
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_PAT, 8'h62);
        repeat (MAX_TEXT - 1)
            send_item(OP_TEXT, 8'h63);
        send_item(OP_TEXT, 8'h62);
        send_item(OP_END, 8'h00);

        // every byte value in the pattern, then pattern overflow
        send_item(OP_CLEAR, 8'h00);
        for (int i = 0; i < SYM_NUM; i++)
            send_item(OP_PAT, 8'(i));
        send_item(OP_PAT, 8'h00);
        send_item(OP_END, 8'h00);
        for (int i = SYM_NUM - 1; i >= 0; i--)
            send_item(OP_TEXT, 8'(i));
        send_item(OP_END, 8'h00);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_mix[p][0];
            stall_pct     = idle_mix[p][1];
            if (p == 0)
            begin
                hold_req = 1'b1;
                repeat (8)
                begin
                    send_item(OP_CLEAR, 8'h00);
                    send_item(OP_PAT, 8'h10);
                    send_item(OP_TEXT, 8'h10);
                    send_item(OP_END, 8'h00);
                end
            end
            mark = sent_cnt;
            while (sent_cnt - mark < RANDOM_ITEMS / 4)
                random_case();
        end
        send_item(OP_END, 8'h00);
        item_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** minimum_covering_window_core: PASSED **");
        else
            $display("** minimum_covering_window_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mcw_pkg.sv
src/mcw_count_mem.sv
src/mcw_text_mem.sv
src/minimum_covering_window_core.sv
tb/minimum_covering_window_checker.sv
tb/minimum_covering_window_core_tb.sv
